@@ hw/rtl/kcsm_pkg.sv @@
package kcsm_pkg;

    localparam int WindowDepth  = 6;
    localparam int KeywordMax   = WindowDepth + 1;
    localparam int KeywordCount = 8;
    localparam int HarmCount    = 4;
    localparam int CharWidth    = 8;
    localparam int CfgIndexWidth = 8;

    typedef logic [CharWidth-1:0] char_t;

    // Position 0 is the newest character, position i the one i transfers earlier.
    typedef logic [KeywordMax-1:0][CharWidth-1:0] tail_t;
    typedef logic [KeywordMax-1:0] tail_mask_t;

    typedef logic [CfgIndexWidth-1:0] cfg_index_t;

    localparam cfg_index_t CFG_SAFETY_TRACKED = cfg_index_t'(0);
    localparam cfg_index_t CFG_TRUTH_TRACKED  = cfg_index_t'(1);

    // Keywords stored with their last character at position 0; harmful class first.
    localparam tail_t KW_TAIL [KeywordCount] = '{
        {24'd0, "harm"},
        {8'd0,  "damage"},
        "destroy",
        {8'd0,  "attack"},
        {32'd0, "lie"},
        "deceive",
        {24'd0, "fake"},
        "mislead"
    };

    localparam tail_mask_t KW_MASK [KeywordCount] = '{
        7'b0001111,
        7'b0111111,
        7'b1111111,
        7'b0111111,
        7'b0000111,
        7'b1111111,
        7'b0001111,
        7'b1111111
    };

    typedef struct packed {
        logic harm;
        logic deceit;
    } class_hits_t;

endpackage

@@ hw/rtl/kcsm_matcher.sv @@
module kcsm_matcher (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  kcsm_pkg::char_t        text_byte,
    input  logic                   last_byte,
    output kcsm_pkg::class_hits_t  seen
);

    kcsm_pkg::char_t window_reg [kcsm_pkg::WindowDepth];
    kcsm_pkg::char_t window_next [kcsm_pkg::WindowDepth];
    logic            harm_seen_reg, harm_seen_next;
    logic            deceit_seen_reg, deceit_seen_next;
    kcsm_pkg::tail_t cur;
    logic [kcsm_pkg::KeywordCount-1:0] kw_hit;

    // newest character plus the window
    always_comb begin
        cur[0] = text_byte;
        for (int i = 1; i < kcsm_pkg::KeywordMax; i++) begin
            cur[i] = window_reg[i-1];
        end
    end

    always_comb begin
        kcsm_pkg::tail_mask_t pos_ok;
        for (int k = 0; k < kcsm_pkg::KeywordCount; k++) begin
            for (int i = 0; i < kcsm_pkg::KeywordMax; i++) begin
                pos_ok[i] = !kcsm_pkg::KW_MASK[k][i] || (cur[i] == kcsm_pkg::KW_TAIL[k][i]);
            end
            kw_hit[k] = &pos_ok;
        end
    end

    assign seen.harm   = harm_seen_reg
                       | (|kw_hit[kcsm_pkg::HarmCount-1:0]);
    assign seen.deceit = deceit_seen_reg
                       | (|kw_hit[kcsm_pkg::KeywordCount-1:kcsm_pkg::HarmCount]);

    // shift in the new character; drop the whole string state after its last byte
    always_comb begin
        harm_seen_next   = harm_seen_reg;
        deceit_seen_next = deceit_seen_reg;
        for (int i = 0; i < kcsm_pkg::WindowDepth; i++) begin
            window_next[i] = window_reg[i];
        end
        if (step) begin
            if (last_byte) begin
                harm_seen_next   = 1'b0;
                deceit_seen_next = 1'b0;
                for (int i = 0; i < kcsm_pkg::WindowDepth; i++) begin
                    window_next[i] = '0;
                end
            end else begin
                harm_seen_next   = seen.harm;
                deceit_seen_next = seen.deceit;
                window_next[0]   = text_byte;
                for (int i = 1; i < kcsm_pkg::WindowDepth; i++) begin
                    window_next[i] = window_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            harm_seen_reg   <= 1'b0;
            deceit_seen_reg <= 1'b0;
            for (int i = 0; i < kcsm_pkg::WindowDepth; i++) begin
                window_reg[i] <= '0;
            end
        end else begin
            harm_seen_reg   <= harm_seen_next;
            deceit_seen_reg <= deceit_seen_next;
            for (int i = 0; i < kcsm_pkg::WindowDepth; i++) begin
                window_reg[i] <= window_next[i];
            end
        end
    end

endmodule

@@ hw/rtl/keyword_class_stream_matcher_unit.sv @@
// Keyword class stream matcher: a string arrives one byte per transfer on the s_ side, its
// final byte marked by s_tlast, and the block looks for eight fixed keywords anywhere in it
// (harmful: harm, damage, destroy, attack; deceptive: lie, deceive, fake, mislead). Only the
// final byte of a string produces a transfer on the m_ side: aligned is 1 when no keyword was
// found; otherwise a harmful match sets the sticky safety_violated flag (if safety tracking
// is on) and, failing that, a deceptive match sets the sticky truth_violated flag (if truth
// tracking is on). Both flags clear only on reset. The block takes one byte every clock; a
// byte is held in the input register and the keyword compare against a six-byte history
// window runs between that register and the result register, so the result register is
// loaded when its final byte leaves the input register. A result that is not taken stalls the
// input only when the next final byte reaches the compare stage. Configuration writes (index
// 0: safety tracking, index 1: truth tracking, bit 0 of cfg_data) are always ready and must
// be issued only while the block is idle; other indices are ignored.
module keyword_class_stream_matcher_unit (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] text_byte
    input  logic                         s_tlast,   // last_byte

    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [0] aligned, [1] safety_violated,
                                                    // [2] truth_violated, [7:3] zero

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  kcsm_pkg::cfg_index_t         cfg_index,
    input  logic                         cfg_data
);

    // input register
    logic            in_valid_reg, in_valid_next;
    kcsm_pkg::char_t in_byte_reg, in_byte_next;
    logic            in_last_reg, in_last_next;

    // configuration
    logic safety_tracked_reg, safety_tracked_next;
    logic truth_tracked_reg, truth_tracked_next;

    // sticky flags
    logic safety_flag_reg, safety_flag_next;
    logic truth_flag_reg, truth_flag_next;

    // result register
    logic m_valid_reg, m_valid_next;
    logic aligned_reg, aligned_next;

    logic                  out_free;
    logic                  advance;
    logic                  finish;
    logic                  s_accept;
    kcsm_pkg::class_hits_t seen;

    // A byte leaves the input register when it produces no result, or when the result
    // register is empty or being emptied this cycle.
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign finish   = advance && in_last_reg;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    kcsm_matcher u_matcher (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .text_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .seen      (seen)
    );

    // Load the input register on every transfer; drop it once it has advanced.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_last_next  = s_tlast;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        safety_tracked_next = safety_tracked_reg;
        truth_tracked_next  = truth_tracked_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                kcsm_pkg::CFG_SAFETY_TRACKED: safety_tracked_next = cfg_data;
                kcsm_pkg::CFG_TRUTH_TRACKED:  truth_tracked_next  = cfg_data;
                default: ;
            endcase
        end
    end

    // Verdict at the final byte: the harmful class wins over the deceptive one.
    always_comb begin
        safety_flag_next = safety_flag_reg;
        truth_flag_next  = truth_flag_reg;
        aligned_next     = aligned_reg;
        m_valid_next     = m_valid_reg;
        if (finish) begin
            m_valid_next     = 1'b1;
            aligned_next     = !(seen.harm || seen.deceit);
            safety_flag_next = safety_flag_reg || (seen.harm && safety_tracked_reg);
            truth_flag_next  = truth_flag_reg
                             || (!seen.harm && seen.deceit && truth_tracked_reg);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            safety_tracked_reg <= 1'b1;
            truth_tracked_reg  <= 1'b1;
            safety_flag_reg    <= 1'b0;
            truth_flag_reg     <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            in_valid_reg       <= in_valid_next;
            safety_tracked_reg <= safety_tracked_next;
            truth_tracked_reg  <= truth_tracked_next;
            safety_flag_reg    <= safety_flag_next;
            truth_flag_reg     <= truth_flag_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
        aligned_reg <= aligned_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, truth_flag_reg, safety_flag_reg, aligned_reg};

    // The sticky flags never clear outside reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(safety_flag_reg) && !$fell(truth_flag_reg))
        else $error("sticky flag cleared");

    // A new result only follows a final byte leaving the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(in_valid_reg && in_last_reg))
        else $error("result without final byte");

    // An aligned string leaves both flags untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && !seen.harm && !seen.deceit) |=>
            (safety_flag_reg == $past(safety_flag_reg))
            && (truth_flag_reg == $past(truth_flag_reg)))
        else $error("flag changed on aligned string");

endmodule
